// ===== design/tmtp_pkg.sv =====
// ----------------------------------------------------------------------------
// tmtp_pkg
// shared types, character codes and helpers for the markup tag parser
// ----------------------------------------------------------------------------
`default_nettype none

package tmtp_pkg;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_HASH  = 8'h23;

  // alignment codes
  localparam logic [1:0] ALIGN_CENTRE = 2'd0;
  localparam logic [1:0] ALIGN_LEFT   = 2'd1;
  localparam logic [1:0] ALIGN_RIGHT  = 2'd2;

  localparam logic [3:0] LEN_COLOUR = 4'd9;
  localparam logic [3:0] LEN_MAX    = 4'd15;
  localparam logic [3:0] LEN_STORE  = 4'd8;
  localparam logic [7:0] COLOUR_RST = 8'h80;
  localparam logic [4:0] DIGIT_BAD  = 5'h1F;

  localparam int DIGITS  = 8;
  localparam int OUT_W   = 40;

  // one character handed to the scanner
  typedef struct packed {
    logic       valid;
    logic [7:0] ch;
  } step_t;

  // one result item
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic [1:0] align_mode;
  } result_t;

  // digit value as 5-bit two's complement, -1 for a non-hex character
  function automatic logic [4:0] hex_value(input logic [7:0] ch);
    logic [4:0] v;
    v = DIGIT_BAD;
    if (ch >= 8'h30 && ch <= 8'h39) v = 5'(ch - 8'h30);
    else if (ch >= 8'h41 && ch <= 8'h46) v = 5'(ch - 8'h41 + 8'd10);
    else if (ch >= 8'h61 && ch <= 8'h66) v = 5'(ch - 8'h61 + 8'd10);
    return v;
  endfunction

  // hi*16 + lo modulo 256 with both digits signed
  function automatic logic [7:0] colour_byte(input logic [4:0] hi, input logic [4:0] lo);
    return {hi[3:0], 4'b0000} + {{3{lo[4]}}, lo};
  endfunction

endpackage

`default_nettype wire

// ===== design/tmtp_scan.sv =====
// ----------------------------------------------------------------------------
// tmtp_scan
// tag state, digit store and persistent alignment and colour
// ----------------------------------------------------------------------------
`default_nettype none

module tmtp_scan import tmtp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire step_t   step,
  output result_t      cur
);

  logic       in_tag_r, in_tag_nxt;
  logic [3:0] len_r, len_nxt;
  logic [7:0] first_r, first_nxt;
  logic [1:0] align_r, align_nxt;
  logic [7:0] colour_r [4];
  logic [7:0] colour_nxt [4];
  logic [4:0] digit_r [DIGITS];
  logic       digit_we;
  logic [2:0] digit_idx;

  always_comb begin
    in_tag_nxt = in_tag_r;
    len_nxt    = len_r;
    first_nxt  = first_r;
    align_nxt  = align_r;
    for (int k = 0; k < 4; k++) colour_nxt[k] = colour_r[k];
    digit_we   = 1'b0;
    digit_idx  = 3'(len_r - 4'd1);

    if (step.ch == CH_NUL) begin
      in_tag_nxt = 1'b0;
      len_nxt    = '0;
      first_nxt  = '0;
    end else if (step.ch == CH_OPEN) begin
      in_tag_nxt = 1'b1;
      len_nxt    = '0;
      first_nxt  = '0;
    end else if (step.ch == CH_CLOSE) begin
      if (in_tag_r) begin
        if (len_r != '0) begin
          if (first_r == CH_L) align_nxt = ALIGN_LEFT;
          else if (first_r == CH_R) align_nxt = ALIGN_RIGHT;
          else if (first_r == CH_C) align_nxt = ALIGN_CENTRE;
          else if (first_r == CH_HASH && len_r == LEN_COLOUR) begin
            for (int k = 0; k < 4; k++)
              colour_nxt[k] = colour_byte(digit_r[2*k], digit_r[2*k+1]);
          end
        end
        in_tag_nxt = 1'b0;
        len_nxt    = '0;
        first_nxt  = '0;
      end
    end else if (in_tag_r) begin
      if (len_r == '0) first_nxt = step.ch;
      else if (len_r <= LEN_STORE) digit_we = 1'b1;
      if (len_r < LEN_MAX) len_nxt = len_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_tag_r <= 1'b0;
      len_r    <= '0;
      first_r  <= '0;
      align_r  <= ALIGN_CENTRE;
      for (int k = 0; k < 4; k++) colour_r[k] <= COLOUR_RST;
    end else if (step.valid) begin
      in_tag_r <= in_tag_nxt;
      len_r    <= len_nxt;
      first_r  <= first_nxt;
      align_r  <= align_nxt;
      for (int k = 0; k < 4; k++) colour_r[k] <= colour_nxt[k];
    end
  end

  // digit store, no reset: every colour tag writes all eight entries first
  always_ff @(posedge clk) begin
    if (step.valid && digit_we) digit_r[digit_idx] <= hex_value(step.ch);
  end

  assign cur.align_mode = align_r;
  assign cur.red        = colour_r[0];
  assign cur.green      = colour_r[1];
  assign cur.blue       = colour_r[2];
  assign cur.alpha      = colour_r[3];

endmodule

`default_nettype wire

// ===== design/tmtp_out_reg.sv =====
// ----------------------------------------------------------------------------
// tmtp_out_reg
// result register on the master side
// ----------------------------------------------------------------------------
`default_nettype none

module tmtp_out_reg import tmtp_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    load,
  input  wire result_t data_in,
  input  wire logic    take,
  output logic         valid,
  output result_t      data_out
);

  logic    valid_r;
  result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= data_in;
  end

  assign valid    = valid_r;
  assign data_out = data_r;

endmodule

`default_nettype wire

// ===== design/text_markup_tag_parser_unit.sv =====
// ----------------------------------------------------------------------------
// text_markup_tag_parser_unit
// brace tag scanner: alignment and colour tags, one result per string end
// ----------------------------------------------------------------------------
//
//  channel | dir | fields
//  --------+-----+-----------------------------------------------------------
//  in_     | in  | char_code[7:0]
//  out_    | out | align_mode[1:0] red[9:2] green[17:10] blue[25:18]
//          |     | alpha[33:26], zero padded to 40 bits
//
//  one character per cycle unless a zero character stalls; a character waits in
//  the input register and its state update and result load happen as it leaves it
//  a zero character passes through the input register, then the result register
//  synchronous active-low reset: centre alignment, colour 0x80 per byte
//  a zero character waits in the input register only while the result
//  register still holds an untaken result; other characters never stall
// ----------------------------------------------------------------------------
`default_nettype none

module text_markup_tag_parser_unit import tmtp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [7:0]       in_tdata,   // char_code[7:0]
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [OUT_W-1:0]      out_tdata   // align_mode, red, green, blue, alpha
);

  // input register
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       advance;
  logic       is_end;

  // result side
  logic    out_valid;
  result_t cur;
  result_t res;
  step_t   step;

  assign is_end = (in_char_r == CH_NUL);

  // a string end needs a free result register, or one being emptied now
  assign advance   = in_valid_r && (!is_end || !out_valid || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_char_r <= in_tdata;
  end

  assign step.valid = advance;
  assign step.ch    = in_char_r;

  // tag state; cur shows alignment and colour before this character
  tmtp_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cur   (cur)
  );

  tmtp_out_reg u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (advance && is_end),
    .data_in  (cur),
    .take     (out_tready),
    .valid    (out_valid),
    .data_out (res)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {6'b000000, res};

endmodule

`default_nettype wire

// ===== design/tmtp_checker.sv =====
// ----------------------------------------------------------------------------
// tmtp_checker
// port-level checks on the tag parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tmtp_checker import tmtp_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_tvalid,
  input wire logic             in_tready,
  input wire logic [7:0]       in_tdata,
  input wire logic             out_tvalid,
  input wire logic             out_tready,
  input wire logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a new result follows a string end taken at the input
  a_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready && in_tdata == CH_NUL, 2))
    else $error("result without a string end");

  // with the result side empty the input never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

endmodule

bind text_markup_tag_parser_unit tmtp_checker u_tmtp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
